// ===== rtl/infix_expression_evaluator_macros.svh =====
// Assertion macros for the infix expression evaluator
`ifndef INFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define INFIX_EXPRESSION_EVALUATOR_MACROS_SVH
// Assert that a condition implies a consequence in the same cycle
`define IEE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle
`define IEE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/iee_pkg.sv =====
// ----------------------------------------------------------------------------
// iee_pkg
// Types and constants shared by the infix expression evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_LPAR = 3'd4;

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_LPAR  = 8'd40;
    localparam logic [7:0] CH_RPAR  = 8'd41;
    localparam logic [7:0] CH_MUL   = 8'd42;
    localparam logic [7:0] CH_ADD   = 8'd43;
    localparam logic [7:0] CH_SUB   = 8'd45;
    localparam logic [7:0] CH_DIV   = 8'd47;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    typedef logic [2:0] op_code_t;
endpackage

// ===== rtl/iee_if.sv =====
// ----------------------------------------------------------------------------
// iee_in_if / iee_out_if
// Valid/ready channels of the infix expression evaluator.
// ----------------------------------------------------------------------------
interface iee_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       end_mark;
    modport source (output valid, output symbol, output end_mark, input ready);
    modport sink   (input valid, input symbol, input end_mark, output ready);
endinterface

interface iee_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic [1:0]         status;
    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

// ===== rtl/iee_ram.sv =====
// ----------------------------------------------------------------------------
// iee_ram
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// ----------------------------------------------------------------------------
module iee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/infix_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// Two-stack infix evaluator driven by a small sequencer and one shared
// arithmetic unit (adder, 32x32 multiplier, bit-serial divider).
// ----------------------------------------------------------------------------
// Usage:
//   in  : one ASCII character per transfer (symbol); end_mark=1 ends the
//         expression and yields one transfer on out (value, status).
//   out : value is the top of the value stack after the final reduction,
//         status 0 ok, 1 divide by zero, 2 malformed or overflow.
// Sequencing:
//   Each character is taken in S_IDLE and decoded in S_DISP. A reduction
//   reads the operator stack, then b and a from the value stack, executes and
//   pushes the result; the shared divider makes one quotient bit per cycle.
//   in.ready is low while a character is being worked on.
// Reset:
//   Clears counts, accumulator and flags; stack contents stay undefined.
// Stall:
//   A result waits in the output register until taken; the next character is
//   accepted meanwhile, and the next result waits until the first is gone.
// ----------------------------------------------------------------------------
`include "infix_expression_evaluator_macros.svh"

module infix_expression_evaluator
    import iee_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    iee_in_if.sink    in_ch,
    iee_out_if.source out_ch
);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int VW = VALUE_WIDTH;
    localparam int DCW = $clog2(VW + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_LOOP   = 4'd2;
    localparam logic [3:0] S_RD_OP  = 4'd3;
    localparam logic [3:0] S_CHK    = 4'd4;
    localparam logic [3:0] S_RD_B   = 4'd5;
    localparam logic [3:0] S_RD_A   = 4'd6;
    localparam logic [3:0] S_EXEC   = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_PUSHR  = 4'd9;
    localparam logic [3:0] S_FINAL  = 4'd10;
    localparam logic [3:0] S_FRD    = 4'd11;
    localparam logic [3:0] S_EMIT   = 4'd12;
    localparam logic [3:0] S_PUSHOP = 4'd13;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] vcnt_reg, vcnt_next, ocnt_reg, ocnt_next;
    logic [VW-1:0] acc_reg, acc_next;
    logic          innum_reg, innum_next;
    logic [1:0]    err_reg, err_next;
    logic [7:0]    sym_reg, sym_next;
    logic          endm_reg, endm_next;
    op_code_t      cur_reg, cur_next;
    op_code_t      top_reg, top_next;
    logic [VW-1:0] a_reg, a_next, b_reg, b_next;
    logic [VW-1:0] r_reg, r_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] quo_reg, quo_next;
    logic [DCW-1:0] dcnt_reg, dcnt_next;
    logic          neg_reg, neg_next;
    logic          ov_reg, ov_next;
    logic [31:0]   oval_reg, oval_next;
    logic [1:0]    ost_reg, ost_next;

    logic           v_we, o_we;
    logic [AW-1:0]  v_wa, v_ra, o_wa, o_ra;
    logic [VW-1:0]  v_wd, v_rd;
    op_code_t       o_wd, o_rd;

    logic [VW-1:0]   mul_lo;
    logic [VW:0]     trial;
    logic [VW-1:0]   rem_sh;
    logic            is_digit, is_op;
    op_code_t        sym_op;

    iee_ram #(.WIDTH(VW), .DEPTH(STACK_DEPTH)) u_vstack (
        .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd)
    );
    iee_ram #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_ostack (
        .clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd)
    );

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = ov_reg;
    assign out_ch.value = oval_reg;
    assign out_ch.status = ost_reg;

    assign is_digit = (sym_reg >= CH_ZERO) && (sym_reg <= CH_NINE);
    assign is_op = (sym_reg == CH_ADD) || (sym_reg == CH_SUB) ||
                   (sym_reg == CH_MUL) || (sym_reg == CH_DIV);
    always_comb
    begin
        case (sym_reg)
            CH_ADD:  sym_op = OP_ADD;
            CH_SUB:  sym_op = OP_SUB;
            CH_MUL:  sym_op = OP_MUL;
            default: sym_op = OP_DIV;
        endcase
    end

    // shared multiplier: acc*10 (digit added after) or a*b, low VW bits
    always_comb
    begin
        if (state_reg == S_EXEC)
        begin
            mul_lo = a_reg * b_reg;
        end
        else
        begin
            mul_lo = acc_reg * VW'(10);
        end
    end

    assign rem_sh = {rem_reg[VW-2:0], quo_reg[VW-1]};
    assign trial  = {1'b0, rem_sh} - {1'b0, b_reg};

    always_comb
    begin
        state_next = state_reg;
        vcnt_next = vcnt_reg;
        ocnt_next = ocnt_reg;
        acc_next = acc_reg;
        innum_next = innum_reg;
        err_next = err_reg;
        sym_next = sym_reg;
        endm_next = endm_reg;
        cur_next = cur_reg;
        top_next = top_reg;
        a_next = a_reg;
        b_next = b_reg;
        r_next = r_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        dcnt_next = dcnt_reg;
        neg_next = neg_reg;
        ov_next = ov_reg;
        oval_next = oval_reg;
        ost_next = ost_reg;
        v_we = 1'b0;
        v_wa = vcnt_reg[AW-1:0];
        v_wd = acc_reg;
        v_ra = vcnt_reg[AW-1:0] - AW'(1);
        o_we = 1'b0;
        o_wa = ocnt_reg[AW-1:0];
        o_wd = cur_reg;
        o_ra = ocnt_reg[AW-1:0] - AW'(1);

        if (ov_reg && out_ch.ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    sym_next = in_ch.symbol;
                    endm_next = in_ch.end_mark;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (!endm_reg && is_digit)
                begin
                    acc_next = mul_lo + VW'(sym_reg - CH_ZERO);
                    innum_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    // flush pending number
                    if (innum_reg)
                    begin
                        if (vcnt_reg >= FULL)
                        begin
                            err_next[1] = 1'b1;
                        end
                        else
                        begin
                            v_we = 1'b1;
                            vcnt_next = vcnt_reg + CW'(1);
                        end
                    end
                    innum_next = 1'b0;
                    acc_next = '0;
                    cur_next = sym_op;
                    if (endm_reg || sym_reg == CH_RPAR || is_op)
                    begin
                        state_next = S_LOOP;
                    end
                    else if (sym_reg == CH_LPAR)
                    begin
                        cur_next = OP_LPAR;
                        state_next = S_PUSHOP;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_LOOP:
            begin
                if (ocnt_reg == '0)
                begin
                    if (endm_reg)
                    begin
                        state_next = S_FINAL;
                    end
                    else if (sym_reg == CH_RPAR)
                    begin
                        err_next[1] = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_PUSHOP;
                    end
                end
                else
                begin
                    state_next = S_RD_OP;
                end
            end
            S_RD_OP:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                top_next = o_rd;
                if (endm_reg)
                begin
                    state_next = S_RD_B;
                end
                else if (sym_reg == CH_RPAR)
                begin
                    if (o_rd == OP_LPAR)
                    begin
                        ocnt_next = ocnt_reg - CW'(1);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_RD_B;
                    end
                end
                else
                begin
                    if (o_rd == OP_LPAR ||
                        ((cur_reg == OP_MUL || cur_reg == OP_DIV) &&
                         (o_rd == OP_ADD || o_rd == OP_SUB)))
                    begin
                        state_next = S_PUSHOP;
                    end
                    else
                    begin
                        state_next = S_RD_B;
                    end
                end
                if (state_next == S_RD_B)
                begin
                    ocnt_next = ocnt_reg - CW'(1);
                    if (o_rd == OP_LPAR || vcnt_reg < CW'(2))
                    begin
                        err_next[1] = 1'b1;
                        state_next = S_LOOP;
                    end
                    else
                    begin
                        v_ra = vcnt_reg[AW-1:0] - AW'(1);
                    end
                end
            end
            S_RD_B:
            begin
                v_ra = vcnt_reg[AW-1:0] - AW'(2);
                b_next = v_rd;
                state_next = S_RD_A;
            end
            S_RD_A:
            begin
                a_next = v_rd;
                vcnt_next = vcnt_reg - CW'(2);
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_PUSHR;
                case (top_reg)
                    OP_ADD: r_next = a_reg + b_reg;
                    OP_SUB: r_next = a_reg - b_reg;
                    OP_MUL: r_next = mul_lo;
                    default:
                    begin
                        if (b_reg == '0)
                        begin
                            err_next[0] = 1'b1;
                            r_next = '1;
                        end
                        else
                        begin
                            neg_next = a_reg[VW-1] ^ b_reg[VW-1];
                            quo_next = a_reg[VW-1] ? (VW'(0) - a_reg) : a_reg;
                            b_next = b_reg[VW-1] ? (VW'(0) - b_reg) : b_reg;
                            rem_next = '0;
                            dcnt_next = DCW'(VW);
                            state_next = S_DIV;
                        end
                    end
                endcase
            end
            S_DIV:
            begin
                if (dcnt_reg == '0)
                begin
                    r_next = neg_reg ? (VW'(0) - quo_reg) : quo_reg;
                    state_next = S_PUSHR;
                end
                else
                begin
                    if (!trial[VW])
                    begin
                        rem_next = trial[VW-1:0];
                    end
                    else
                    begin
                        rem_next = rem_sh;
                    end
                    quo_next = {quo_reg[VW-2:0], ~trial[VW]};
                    dcnt_next = dcnt_reg - DCW'(1);
                end
            end
            S_PUSHR:
            begin
                // two values were popped, so room always exists
                v_we = 1'b1;
                v_wd = r_reg;
                vcnt_next = vcnt_reg + CW'(1);
                state_next = S_LOOP;
            end
            S_PUSHOP:
            begin
                if (ocnt_reg >= FULL)
                begin
                    err_next[1] = 1'b1;
                end
                else
                begin
                    o_we = 1'b1;
                    ocnt_next = ocnt_reg + CW'(1);
                end
                state_next = S_IDLE;
            end
            S_FINAL:
            begin
                state_next = S_FRD;
            end
            S_FRD:
            begin
                if (!ov_next)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (vcnt_reg == '0)
                begin
                    oval_next = '0;
                    err_next[1] = 1'b1;
                end
                else
                begin
                    oval_next = 32'(v_rd);
                end
                ost_next = (err_next[1]) ? ST_BAD : (err_next[0] ? ST_DIV0 : ST_OK);
                ov_next = 1'b1;
                vcnt_next = '0;
                ocnt_next = '0;
                acc_next = '0;
                innum_next = 1'b0;
                err_next = '0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vcnt_reg <= '0;
            ocnt_reg <= '0;
            acc_reg <= '0;
            innum_reg <= 1'b0;
            err_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vcnt_reg <= vcnt_next;
            ocnt_reg <= ocnt_next;
            acc_reg <= acc_next;
            innum_reg <= innum_next;
            err_reg <= err_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg <= sym_next;
        endm_reg <= endm_next;
        cur_reg <= cur_next;
        top_reg <= top_next;
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dcnt_reg <= dcnt_next;
        neg_reg <= neg_next;
        oval_reg <= oval_next;
        ost_reg <= ost_next;
    end

    `IEE_ASSERT_IMP(a_cnt_bound, 1'b1, (vcnt_reg <= FULL) && (ocnt_reg <= FULL))
    `IEE_ASSERT_NEXT(a_emit_valid, state_reg == S_EMIT, ov_reg && state_reg == S_IDLE)
    `IEE_ASSERT_IMP(a_status_code, ov_reg, ost_reg != 2'd3)
    `IEE_ASSERT_NEXT(a_div_steps, state_reg == S_DIV && dcnt_reg != '0,
        state_reg == S_DIV && dcnt_reg == $past(dcnt_reg) - DCW'(1))
endmodule
